// ===== hw/rtl/frth_pkg.sv =====
// ----------------------------------------------------------------------------
// frth_pkg: shared definitions for the filtered reaction tally histogram
// command codes, register indexes, stream widths and controller interface types
// ----------------------------------------------------------------------------
`default_nettype none

package frth_pkg;

    // default sizing
    localparam int FRTH_CELL_COUNT     = 1024;
    localparam int FRTH_MAX_COLUMNS    = 16;
    localparam int FRTH_SPECIES_COUNT  = 256;
    localparam int FRTH_REACTION_COUNT = 256;

    // stream and config widths
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int MAP_COL_W   = 4;

    // request commands
    localparam logic [2:0] CMD_TALLY  = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_MEMBER = 3'd3;
    localparam logic [2:0] CMD_MAP    = 3'd4;

    // tally modes
    localparam logic [1:0] MODE_ALL    = 2'd0;
    localparam logic [1:0] MODE_EVERY  = 2'd1;
    localparam logic [1:0] MODE_SELECT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TALLY_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SELECT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic sp_sel_second;
        logic capture_m1;
        logic cnt_sel_read;
        logic cnt_update;
        logic capture_read;
        logic sp_wr;
        logic map_wr;
        logic clr_step;
        logic out_load;
    } frth_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       tally_hit;
        logic       clr_last;
        logic       out_free;
    } frth_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frth_ram.sv =====
// ----------------------------------------------------------------------------
// frth_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module frth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/frth_ctrl.sv =====
// ----------------------------------------------------------------------------
// frth_ctrl: request sequencer
// steps each request through table lookups, counter update and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module frth_ctrl import frth_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire frth_status_t sts,
    output frth_cmd_t         ctl
);

    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_FETCH  = 9'b000000100,
        ST_FETCH2 = 9'b000001000,
        ST_DECIDE = 9'b000010000,
        ST_UPDATE = 9'b000100000,
        ST_READ   = 9'b001000000,
        ST_CLEAR  = 9'b010000000,
        ST_RESULT = 9'b100000000
    } frth_state_t;

    frth_state_t state_reg;
    frth_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_INIT:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                case (sts.cmd)
                    CMD_TALLY:  state_next = ST_FETCH2;
                    CMD_CLEAR:  state_next = ST_CLEAR;
                    CMD_READ:
                    begin
                        ctl.cnt_sel_read = 1'b1;
                        state_next       = ST_READ;
                    end
                    CMD_MEMBER:
                    begin
                        ctl.sp_wr  = 1'b1;
                        state_next = ST_RESULT;
                    end
                    CMD_MAP:
                    begin
                        ctl.map_wr = 1'b1;
                        state_next = ST_RESULT;
                    end
                    default:    state_next = ST_RESULT;
                endcase
            end
            ST_FETCH2:
            begin
                // first species lookup lands, second one goes out
                ctl.capture_m1    = 1'b1;
                ctl.sp_sel_second = 1'b1;
                state_next        = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                ctl.sp_sel_second = 1'b1;
                state_next = sts.tally_hit ? ST_UPDATE : ST_RESULT;
            end
            ST_UPDATE:
            begin
                ctl.cnt_update = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_READ:
            begin
                ctl.capture_read = 1'b1;
                state_next       = ST_RESULT;
            end
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/frth_dp.sv =====
// ----------------------------------------------------------------------------
// frth_dp: histogram datapath
// request and config registers, member and map tables, counter memory, result
// ----------------------------------------------------------------------------
`default_nettype none

module frth_dp import frth_pkg::*; #(
    parameter int CELL_COUNT     = FRTH_CELL_COUNT,
    parameter int MAX_COLUMNS    = FRTH_MAX_COLUMNS,
    parameter int SPECIES_COUNT  = FRTH_SPECIES_COUNT,
    parameter int REACTION_COUNT = FRTH_REACTION_COUNT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [IN_TDATA_W-1:0]  in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [OUT_TDATA_W-1:0] out_data,
    input  wire frth_cmd_t              ctl,
    output frth_status_t                sts
);

    // only cells and keys that the 10 and 8 bit fields can name get storage
    localparam int CELL_EFF  = (CELL_COUNT < 1024) ? CELL_COUNT : 1024;
    localparam int CNT_DEPTH = CELL_EFF * MAX_COLUMNS;
    localparam int CNT_AW    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
    localparam int SP_DEPTH  = (SPECIES_COUNT < 256) ? SPECIES_COUNT : 256;
    localparam int SP_AW     = (SP_DEPTH > 1) ? $clog2(SP_DEPTH) : 1;
    localparam int MAP_DEPTH = (REACTION_COUNT < 256) ? REACTION_COUNT : 256;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    // request fields
    logic [2:0]  item_cmd_reg;
    logic [9:0]  item_cell_reg;
    logic [7:0]  item_rxn_reg;
    logic [7:0]  item_sp1_reg;
    logic [7:0]  item_sp2_reg;
    logic [31:0] item_mask_reg;
    logic [4:0]  item_colv_reg;
    logic        item_flag_reg;

    // configuration
    logic [1:0]  mode_reg;
    logic [31:0] gsel_reg;
    logic [4:0]  ccount_reg;

    logic [CNT_AW-1:0]    clr_addr_reg;
    logic [SP_DEPTH-1:0]  sp_valid_reg;
    logic [MAP_DEPTH-1:0] map_valid_reg;
    logic                 member1_reg;

    logic [31:0] res_value_reg;
    logic        res_counted_reg;
    logic        res_sat_reg;
    logic        out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [SP_AW-1:0]     sp1_idx;
    logic [SP_AW-1:0]     sp2_idx;
    logic [SP_AW-1:0]     sp_raddr;
    logic                 sp_rdata;
    logic                 sp1_ok;
    logic                 sp2_ok;
    logic                 sp_we;
    logic                 member2;
    logic [MAP_AW-1:0]    map_idx;
    logic [MAP_COL_W-1:0] map_rdata;
    logic                 rxn_ok;
    logic                 map_we;
    logic                 map_hit;
    logic                 colv_ok;
    logic                 cell_ok;
    logic                 read_ok;
    logic [7:0]           rxn_m1;
    logic [7:0]           col;
    logic                 have_col;
    logic                 pass;
    logic [31:0]          tally_sum;
    logic [31:0]          read_sum;
    logic [CNT_AW-1:0]    tally_idx;
    logic [CNT_AW-1:0]    read_idx;
    logic [CNT_AW-1:0]    cnt_raddr;
    logic [CNT_AW-1:0]    cnt_waddr;
    logic [31:0]          cnt_wdata;
    logic [31:0]          cnt_rdata;
    logic                 cnt_we;
    logic                 cnt_full;
    logic                 clr_last;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_cmd_reg    <= in_data[2:0];
            item_cell_reg   <= in_data[12:3];
            item_rxn_reg    <= in_data[20:13];
            item_sp1_reg    <= in_data[28:21];
            item_sp2_reg    <= in_data[36:29];
            item_mask_reg   <= in_data[68:37];
            item_colv_reg   <= in_data[73:69];
            item_flag_reg   <= in_data[74];
            res_value_reg   <= '0;
            res_counted_reg <= 1'b0;
            res_sat_reg     <= 1'b0;
        end
        else
        begin
            if (ctl.cnt_update)
            begin
                res_sat_reg     <= cnt_full;
                res_counted_reg <= !cnt_full;
            end
            if (ctl.capture_read)
            begin
                res_value_reg <= read_ok ? cnt_rdata : 32'd0;
            end
        end
        if (ctl.capture_m1)
        begin
            member1_reg <= sp1_ok & sp_valid_reg[sp1_idx] & sp_rdata;
        end
        if (ctl.out_load)
        begin
            out_data_reg <= {6'd0, res_sat_reg, res_counted_reg, res_value_reg};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ALL;
            gsel_reg      <= 32'hFFFF_FFFF;
            ccount_reg    <= 5'd16;
            clr_addr_reg  <= '0;
            sp_valid_reg  <= '0;
            map_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TALLY_MODE:   mode_reg   <= cfg_wdata[1:0];
                    REG_GROUP_SELECT: gsel_reg   <= cfg_wdata;
                    REG_COLUMN_COUNT: ccount_reg <= cfg_wdata[4:0];
                    default:          ;
                endcase
            end
            if (ctl.clr_step)
            begin
                clr_addr_reg <= clr_last ? '0 : clr_addr_reg + CNT_AW'(1);
            end
            if (sp_we)
            begin
                sp_valid_reg[sp1_idx] <= 1'b1;
            end
            if (map_we)
            begin
                map_valid_reg[map_idx] <= colv_ok;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign clr_last = (clr_addr_reg == CNT_AW'(CNT_DEPTH - 1));

    // table addressing and range checks
    assign sp1_idx  = SP_AW'(item_sp1_reg);
    assign sp2_idx  = SP_AW'(item_sp2_reg);
    assign sp1_ok   = (32'(item_sp1_reg) < 32'(SPECIES_COUNT));
    assign sp2_ok   = (32'(item_sp2_reg) < 32'(SPECIES_COUNT));
    assign sp_raddr = ctl.sp_sel_second ? sp2_idx : sp1_idx;
    assign sp_we    = ctl.sp_wr & sp1_ok;
    assign member2  = sp2_ok & sp_valid_reg[sp2_idx] & sp_rdata;

    assign map_idx  = MAP_AW'(item_rxn_reg);
    assign rxn_ok   = (32'(item_rxn_reg) < 32'(REACTION_COUNT));
    assign map_we   = ctl.map_wr & rxn_ok;
    assign map_hit  = rxn_ok & map_valid_reg[map_idx];

    // negative column means none
    assign colv_ok  = !item_colv_reg[4] && (32'(item_colv_reg[3:0]) < 32'(MAX_COLUMNS));
    assign cell_ok  = (32'(item_cell_reg) < 32'(CELL_COUNT));
    assign read_ok  = cell_ok && colv_ok;

    assign rxn_m1   = item_rxn_reg - 8'd1;

    always_comb
    begin
        col      = '0;
        have_col = 1'b0;
        case (mode_reg)
            MODE_ALL:
            begin
                have_col = 1'b1;
            end
            MODE_EVERY:
            begin
                col      = rxn_m1;
                have_col = (rxn_m1 < 8'(ccount_reg)) && (32'(rxn_m1) < 32'(MAX_COLUMNS));
            end
            MODE_SELECT:
            begin
                col      = 8'(map_rdata);
                have_col = map_hit;
            end
            default:
            begin
                have_col = 1'b0;
            end
        endcase
    end

    assign pass = (item_rxn_reg != 8'd0) && ((item_mask_reg & gsel_reg) != 32'd0)
                  && member1_reg && member2 && cell_ok;

    assign tally_sum = 32'(item_cell_reg) * 32'(MAX_COLUMNS) + 32'(col);
    assign read_sum  = 32'(item_cell_reg) * 32'(MAX_COLUMNS) + 32'(item_colv_reg[3:0]);
    assign tally_idx = tally_sum[CNT_AW-1:0];
    assign read_idx  = read_sum[CNT_AW-1:0];

    // counter read-modify-write, or the clearing sweep
    assign cnt_full  = (cnt_rdata == 32'hFFFF_FFFF);
    assign cnt_raddr = ctl.cnt_sel_read ? read_idx : tally_idx;
    assign cnt_waddr = ctl.clr_step ? clr_addr_reg : tally_idx;
    assign cnt_wdata = ctl.clr_step ? 32'd0 : cnt_rdata + 32'd1;
    assign cnt_we    = ctl.clr_step | (ctl.cnt_update & !cnt_full);

    frth_ram #(
        .WIDTH (1),
        .DEPTH (SP_DEPTH)
    ) u_sp_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp1_idx),
        .wdata (item_flag_reg),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    frth_ram #(
        .WIDTH (MAP_COL_W),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_idx),
        .wdata (item_colv_reg[3:0]),
        .raddr (map_idx),
        .rdata (map_rdata)
    );

    frth_ram #(
        .WIDTH (32),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign sts.cmd       = item_cmd_reg;
    assign sts.tally_hit = pass && have_col;
    assign sts.clr_last  = clr_last;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/filtered_reaction_tally_histogram_core.sv =====
// ----------------------------------------------------------------------------
// filtered_reaction_tally_histogram_core: per-cell reaction event histogram
// filters tally requests by group mask and species, bins them by mode and map
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                 contents
//  s_axis   in   s_axis_tvalid/tready      one request (command and fields)
//  m_axis   out  m_axis_tvalid/tready      one result per request
//  cfg      in   cfg_we                    register index and write data
//
//  a tally passes through fetch, the second species lookup, a decide step and,
//  when every filter passes, a counter update before its result; a read takes
//  one read step; a member or map load or a spare command goes straight to its
//  result; the two species lookups through one read port and the registered
//  counter read set the tally path; a clear walks the counter memory one entry
//  per cycle, CELL_COUNT (at most 1024) times MAX_COLUMNS entries in all
//  after reset the same sweep runs before the first request is taken
//  one request at a time; a result waiting in the output register does not
//  hold off the next request until that request's own result is due
//
`default_nettype none

module filtered_reaction_tally_histogram_core import frth_pkg::*; #(
    parameter int CELL_COUNT     = FRTH_CELL_COUNT,
    parameter int MAX_COLUMNS    = FRTH_MAX_COLUMNS,
    parameter int SPECIES_COUNT  = FRTH_SPECIES_COUNT,
    parameter int REACTION_COUNT = FRTH_REACTION_COUNT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // cmd[2:0], cell_index[12:3], reaction_number[20:13], species_first[28:21],
    // species_second[36:29], cell_group_mask[68:37], column_value[73:69],
    // member_flag[74], zero[79:75]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // count_value[31:0], event_counted[32], count_saturated[33], zero[39:34]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    frth_cmd_t    ctl;
    frth_status_t sts;

    frth_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    frth_dp #(
        .CELL_COUNT     (CELL_COUNT),
        .MAX_COLUMNS    (MAX_COLUMNS),
        .SPECIES_COUNT  (SPECIES_COUNT),
        .REACTION_COUNT (REACTION_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .ctl       (ctl),
        .sts       (sts)
    );

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> sts.out_free)
        else $error("result loaded into a full output register");

    // no request accepted during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_step |-> !s_axis_tready)
        else $error("ready during counter clear");

    // a counter update only follows a tally that passed every filter
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cnt_update |-> $past(sts.tally_hit))
        else $error("counter update without a filter hit");

endmodule

`default_nettype wire
